// ----- rtl/core/sqw_pkg.sv -----
// Package for the sleep queue wakeup block.
// Holds the list entry type, status codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package sqw_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_NEGATIVE = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_WOKEN    = 3'd4;

  typedef struct packed {
    logic [7:0]  thread;
    logic [31:0] expiry;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift_en;
    logic load_en;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/sqw_cell.sv -----
// One slot of the sleep list chain.
// Loads a new entry, or takes the entry of its right neighbor on a shift.
// Depends on sqw_pkg.
`timescale 1ns / 1ps

module sqw_cell (
  input  logic               clk,
  input  sqw_pkg::cell_ctrl_t ctrl,
  input  sqw_pkg::entry_t     load_d,
  input  sqw_pkg::entry_t     nb_d,
  output sqw_pkg::entry_t     q
);
  import sqw_pkg::*;

  entry_t data_r;
  entry_t data_nxt;

  always_comb begin
    priority if (ctrl.load_en) begin
      data_nxt = load_d;
    end else if (ctrl.shift_en) begin
      data_nxt = nb_d;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ----- rtl/core/sleep_queue_wakeup_top.sv -----
// Sleep queue wakeup: chain of SLOTS cells holding sleeping threads in request order.
// A sleep request is taken while idle; its result appears in the cycle after it.
// A due tick scans the chain through cell 0, one entry per cycle, while busy is high;
// woken results come during the scan and the final one from the done state after it.
// The receiver cannot stall; every result shows for exactly one cycle on out_valid.
// Synchronous active-low reset empties the list and sets the earliest expiry to all ones.
`timescale 1ns / 1ps

module sleep_queue_wakeup_top #(
  parameter int unsigned SLOTS = sqw_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_thread_id,
  input  logic signed [31:0] in_duration,
  input  logic [31:0] in_now,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_woken_id,
  output logic        out_last
);
  import sqw_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   due_r, due_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic [31:0]   min_r, min_nxt;
  logic [31:0]   now_r, now_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [7:0]    pend_id_r, pend_id_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_id_r, out_id_nxt;
  logic          out_last_r, out_last_nxt;

  entry_t        cell_q [SLOTS];
  cell_ctrl_t    cell_ctrl [SLOTS];
  entry_t        load_d;
  entry_t        head;
  logic          accept;
  logic          do_insert;
  logic          do_step;
  logic          do_keep;
  logic [CW-1:0] wpos;

  assign accept = start && (state_r == S_IDLE);
  assign head   = cell_q[0];
  // Kept entries go behind the unscanned ones and the entries kept so far.
  assign wpos   = count_r - CW'(1) - k_r + keep_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    due_nxt        = due_r;
    k_nxt          = k_r;
    keep_nxt       = keep_r;
    min_nxt        = min_r;
    now_nxt        = now_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    do_insert      = 1'b0;
    do_step        = 1'b0;
    do_keep        = 1'b0;
    load_d         = head;

    unique case (state_r)
      S_IDLE: begin
        if (accept && !in_action) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = in_thread_id;
          out_last_nxt  = 1'b1;
          priority if (in_duration[31]) begin
            out_status_nxt = ST_NEGATIVE;
          end else if (in_duration == 32'sd0) begin
            out_status_nxt = ST_ZERO;
          end else if (count_r >= FULL_CNT) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_QUEUED;
            do_insert      = 1'b1;
            load_d.thread  = in_thread_id;
            load_d.expiry  = in_now + unsigned'(in_duration);
            if (load_d.expiry < due_r) begin
              due_nxt = load_d.expiry;
            end
            count_nxt = count_r + CW'(1);
          end
        end else if (accept && in_action && (in_now >= due_r)) begin
          now_nxt    = in_now;
          k_nxt      = '0;
          keep_nxt   = '0;
          min_nxt    = TIME_MAX;
          pend_v_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (k_r == count_r) begin
          count_nxt = keep_r;
          due_nxt   = min_r;
          state_nxt = S_DONE;
        end else begin
          do_step = 1'b1;
          k_nxt   = k_r + CW'(1);
          if (head.expiry <= now_r) begin
            // Hold each woken thread until the next one is found so the final one can be marked.
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_WOKEN;
              out_id_nxt     = pend_id_r;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = head.thread;
          end else begin
            do_keep  = 1'b1;
            keep_nxt = keep_r + CW'(1);
            if (head.expiry < min_r) begin
              min_nxt = head.expiry;
            end
          end
        end
      end
      S_DONE: begin
        if (pend_v_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_WOKEN;
          out_id_nxt     = pend_id_r;
          out_last_nxt   = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      if (gi == SLOTS - 1) begin : g_tail
        sqw_cell u_cell (
          .clk    (clk),
          .ctrl   (cell_ctrl[gi]),
          .load_d (load_d),
          .nb_d   (cell_q[gi]),
          .q      (cell_q[gi])
        );
      end else begin : g_body
        sqw_cell u_cell (
          .clk    (clk),
          .ctrl   (cell_ctrl[gi]),
          .load_d (load_d),
          .nb_d   (cell_q[gi+1]),
          .q      (cell_q[gi])
        );
      end

      always_comb begin
        cell_ctrl[gi].shift_en = do_step;
        cell_ctrl[gi].load_en  = (do_keep && (wpos[IW-1:0] == IW'(gi))) ||
                                 (do_insert && (count_r[IW-1:0] == IW'(gi)));
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      due_r       <= TIME_MAX;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      due_r       <= due_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    keep_r       <= keep_nxt;
    min_r        <= min_nxt;
    now_r        <= now_nxt;
    pend_id_r    <= pend_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_woken_id = out_id_r;
  assign out_last     = out_last_r;

endmodule

// ----- tb/sleep_queue_wakeup_top_tb.sv -----
// Self-checking testbench for sleep_queue_wakeup_top: directed cases, then random traffic.
// Predicts every result from its own copy of the sleep list; depends on sqw_pkg and the RTL.
`timescale 1ns / 1ps

module sleep_queue_wakeup_top_tb;
  import sqw_pkg::*;

  localparam int unsigned LIST_DEPTH = SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] id;
    logic       last;
  } wake_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [7:0]  in_thread_id;
  logic signed [31:0] in_duration;
  logic [31:0] in_now;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_woken_id;
  logic        out_last;

  // Predicted contents of the sleep list.
  logic [7:0]  sleeper_id  [LIST_DEPTH];
  logic [31:0] sleeper_due [LIST_DEPTH];
  int unsigned sleeper_count;
  logic [31:0] next_due;

  wake_result_t pending_results[$];
  wake_result_t head_result;
  int unsigned  error_count;
  int unsigned  cycle_count;
  logic [31:0]  clock_now;

  sleep_queue_wakeup_top #(
    .SLOTS(LIST_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_thread_id (in_thread_id),
    .in_duration  (in_duration),
    .in_now       (in_now),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_woken_id (out_woken_id),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic push_result(input logic [2:0] status, input logic [7:0] id,
                             input logic last);
    wake_result_t r;
    r.status = status;
    r.id     = id;
    r.last   = last;
    pending_results.push_back(r);
  endtask

  task automatic predict_outcome(input logic act, input logic [7:0] tid,
                                 input logic [31:0] dur, input logic [31:0] now);
    logic [31:0] due;
    logic [31:0] new_due;
    int unsigned keep;
    int unsigned woke;
    if (act == ACT_SLEEP) begin
      if (dur[31]) begin
        push_result(ST_NEGATIVE, tid, 1'b1);
      end else if (dur == 32'd0) begin
        push_result(ST_ZERO, tid, 1'b1);
      end else if (sleeper_count >= LIST_DEPTH) begin
        push_result(ST_FULL, tid, 1'b1);
      end else begin
        due = now + dur;
        if (due < next_due) next_due = due;
        sleeper_id[sleeper_count]  = tid;
        sleeper_due[sleeper_count] = due;
        sleeper_count++;
        push_result(ST_QUEUED, tid, 1'b1);
      end
      return;
    end
    if (now < next_due) return;
    keep = 0;
    woke = 0;
    new_due = TIME_MAX;
    for (int i = 0; i < sleeper_count; i++) begin
      if (sleeper_due[i] <= now) begin
        push_result(ST_WOKEN, sleeper_id[i], 1'b0);
        woke++;
      end else begin
        if (sleeper_due[i] < new_due) new_due = sleeper_due[i];
        sleeper_id[keep]  = sleeper_id[i];
        sleeper_due[keep] = sleeper_due[i];
        keep++;
      end
    end
    sleeper_count = keep;
    next_due = new_due;
    // The final woken thread of this tick carries the last flag.
    if (woke > 0) pending_results[pending_results.size() - 1].last = 1'b1;
  endtask

  // Drives one request and waits until the block takes it.
  task automatic send_request(input logic act, input logic [7:0] tid,
                              input logic [31:0] dur, input logic [31:0] now);
    @(negedge clk);
    start        <= 1'b1;
    in_action    <= act;
    in_thread_id <= tid;
    in_duration  <= dur;
    in_now       <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_outcome(act, tid, dur, now);
  endtask

  task automatic send_tick(input logic [31:0] now);
    send_request(ACT_TICK, 8'($urandom_range(255)), $urandom, now);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain_results();
    idle_cycle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_sleep_answers();
    send_request(ACT_SLEEP, 8'd0, 32'h8000_0000, 32'd0);
    send_request(ACT_SLEEP, 8'd255, 32'hFFFF_FFFF, TIME_MAX);
    send_request(ACT_SLEEP, 8'h5A, 32'd0, $urandom);
  endtask

  task automatic test_idle_ticks();
    // An early tick on the empty list, then one that scans an empty list.
    send_tick(32'd0);
    send_tick(TIME_MAX);
  endtask

  task automatic test_full_list();
    for (int i = 0; i < LIST_DEPTH; i++) begin
      send_request(ACT_SLEEP, 8'(i * 17), 32'(i + 1), 32'd100);
    end
    send_request(ACT_SLEEP, 8'hA5, 32'd3, 32'd100);
    // Every entry is due, so one tick wakes the whole list.
    send_tick(32'd100 + LIST_DEPTH);
  endtask

  task automatic test_wrap_expiry();
    send_request(ACT_SLEEP, 8'd255, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
    send_tick(32'h7FFF_FFEF);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct);
    logic [31:0] dur;
    int r;
    int burst_left;
    burst_left = 0;
    for (int k = 0; k < n_items; k++) begin
      while ($urandom_range(99) < idle_pct) idle_cycle();
      r = $urandom_range(99);
      if (burst_left > 0 || r < 40) begin
        if (burst_left > 0) burst_left--;
        send_request(ACT_SLEEP, 8'($urandom_range(255)), $urandom_range(40, 1), clock_now);
      end else if (r < 43) begin
        // A run of sleep requests pushes the list toward full.
        burst_left = $urandom_range(20, 8);
        send_request(ACT_SLEEP, 8'($urandom_range(255)), $urandom_range(40, 1), clock_now);
      end else if (r < 51) begin
        case ($urandom_range(2))
          0: dur = 32'd0;
          1: dur = $urandom | 32'h8000_0000;
          default: begin
            dur = $urandom & 32'h7FFF_FFFF;
            if (dur == 32'd0) dur = 32'd1;
          end
        endcase
        send_request(ACT_SLEEP, 8'($urandom_range(255)), dur, clock_now);
      end else if (r < 90) begin
        clock_now = clock_now + $urandom_range(8);
        send_tick(clock_now);
      end else if (r < 95) begin
        // Jump the time base, often close to wraparound.
        clock_now = $urandom_range(1) ? $urandom : TIME_MAX - $urandom_range(40);
        send_tick(clock_now);
      end else begin
        send_tick($urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d woken_id %0d last %0d",
               out_status, out_woken_id, out_last);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_status !== head_result.status) begin
          $error("status: expected %0d, actual %0d", head_result.status, out_status);
          error_count++;
        end
        if (out_woken_id !== head_result.id) begin
          $error("woken_id: expected %0d, actual %0d", head_result.id, out_woken_id);
          error_count++;
        end
        if (out_last !== head_result.last) begin
          $error("last: expected %0d, actual %0d", head_result.last, out_last);
          error_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sleep_queue_wakeup_top_tb failed");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_action     = ACT_SLEEP;
    in_thread_id  = 8'd0;
    in_duration   = 32'd0;
    in_now        = 32'd0;
    sleeper_count = 0;
    next_due      = TIME_MAX;
    error_count   = 0;
    clock_now     = 32'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_sleep_answers();
    test_idle_ticks();
    test_full_list();
    test_wrap_expiry();
    drain_results();
    test_random_traffic(120, 14);
    drain_results();
    test_random_traffic(120, 64);
    drain_results();
    test_random_traffic(120, 0);
    drain_results();
    repeat (LIST_DEPTH + 4) @(posedge clk);

    if (error_count == 0) begin
      $display("sleep_queue_wakeup_top_tb passed");
    end else begin
      $display("sleep_queue_wakeup_top_tb failed");
    end
    $finish;
  end

endmodule
